// ===== rtl/json_token_scanner_unit_defines.svh =====
// Assertion macros for the JSON token scanner.
// Used by rtl/json_token_scanner_unit.sv; expects clk and arst_n in scope.
`ifndef JSON_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define JSON_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jts_pkg.sv =====
// Shared types and constants for the JSON token scanner.
// No dependencies; used by rtl/json_token_scanner_unit.sv.
`default_nettype none

package jts_pkg;

	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned QUEUE_DEPTH       = 4;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_STRING = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_TRUE   = 3'd3,
		MODE_FALSE  = 3'd4,
		MODE_ERROR  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_SYMBOL = 3'd0,
		KIND_STRING = 3'd1,
		KIND_NUMBER = 3'd2,
		KIND_BOOL   = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  sym;
		logic        bval;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	// Letters of "true" and "false" by index.
	function automatic logic [7:0] keyword_char(input logic is_true, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (is_true) begin
			case (idx)
				3'd0: c = 8'h74;
				3'd1: c = 8'h72;
				3'd2: c = 8'h75;
				3'd3: c = 8'h65;
				default: c = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd0: c = 8'h66;
				3'd1: c = 8'h61;
				3'd2: c = 8'h6C;
				3'd3: c = 8'h73;
				3'd4: c = 8'h65;
				default: c = 8'h00;
			endcase
		end
		return c;
	endfunction

	function automatic logic [2:0] keyword_len(input logic is_true);
		return is_true ? 3'd4 : 3'd5;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/json_token_scanner_unit.sv =====
// JSON token scanner top level: byte input register, lexer decode, token queue.
// Depends on rtl/jts_pkg.sv and rtl/json_token_scanner_unit_defines.svh.
`default_nettype none

`include "json_token_scanner_unit_defines.svh"

// Byte-serial JSON lexer. Each accepted text request carries one byte; it is
// held in an input register, decoded combinationally against the scanner
// state, and its zero, one or two token records are written into a
// four-entry queue when the byte advances; the queue head drives the token
// outputs. One byte is taken per cycle while text_stall is low; a byte that
// yields two tokens (a number ended by a symbol or a bad byte) fills two
// queue entries, so the sustained output rate of one token per cycle while
// token_stall is low is set by the queue's single read port. text_stall
// rises only when the input register holds a byte and the queue could not
// take two more records. first_byte restarts position, line count and mode
// before its byte is decoded; an open token is then dropped. Positions
// saturate at 2^POSITION_BITS-1 and lines at 65535; output offsets and
// lengths saturate at 65535. After a bad byte the scanner emits nothing
// more until a byte marked first.
module json_token_scanner_unit #(
	parameter int unsigned POSITION_BITS = jts_pkg::POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        first_byte,
	output logic             token_valid,
	input  wire logic        token_stall,
	output logic [2:0]       token_kind,
	output logic [7:0]       symbol_byte,
	output logic             bool_value,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic [15:0]      line_number,
	output logic             last_of_run
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam int unsigned QD = jts_pkg::QUEUE_DEPTH;
	localparam int unsigned QA = $clog2(QD);
	localparam int unsigned QC = $clog2(QD + 1);

	// ---------------------------------------------------------------- input stage
	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic       first_byte_s1;
	logic       accept;
	logic       go;

	assign accept     = text_valid && !text_stall;
	assign text_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			text_byte_s1  <= text_byte;
			first_byte_s1 <= first_byte;
		end
	end

	// ---------------------------------------------------------------- scanner state
	jts_pkg::mode_t           mode_q;
	logic [2:0]               kidx_q;
	logic                     bs_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] ots_q;
	logic [15:0]              line_q;

	// A first byte sees the reset state instead of the stored one.
	jts_pkg::mode_t           mode_e;
	logic [2:0]               kidx_e;
	logic                     bs_e;
	logic [POSITION_BITS-1:0] pos_e;
	logic [POSITION_BITS-1:0] ots_e;
	logic [15:0]              line_e;

	assign mode_e = first_byte_s1 ? jts_pkg::MODE_IDLE : mode_q;
	assign kidx_e = first_byte_s1 ? 3'd0 : kidx_q;
	assign bs_e   = first_byte_s1 ? 1'b0 : bs_q;
	assign pos_e  = first_byte_s1 ? '0 : pos_q;
	assign ots_e  = first_byte_s1 ? '0 : ots_q;
	assign line_e = first_byte_s1 ? 16'd1 : line_q;

	// ---------------------------------------------------------------- byte classes
	logic [7:0] b;
	logic       is_ws, is_sym, is_quote, is_bslash, is_digit, is_dot, is_t, is_f;

	assign b         = text_byte_s1;
	assign is_ws     = b inside {jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_CR,
		jts_pkg::CH_LF};
	assign is_sym    = b inside {jts_pkg::CH_LBRACK, jts_pkg::CH_RBRACK, jts_pkg::CH_LBRACE,
		jts_pkg::CH_RBRACE, jts_pkg::CH_COMMA, jts_pkg::CH_COLON};
	assign is_quote  = (b == jts_pkg::CH_QUOTE);
	assign is_bslash = (b == jts_pkg::CH_BSLASH);
	assign is_digit  = b inside {[jts_pkg::CH_ZERO:jts_pkg::CH_NINE]};
	assign is_dot    = (b == jts_pkg::CH_DOT);
	assign is_t      = (b == jts_pkg::CH_T);
	assign is_f      = (b == jts_pkg::CH_F);

	// ---------------------------------------------------------------- shared arithmetic
	logic [POSITION_BITS-1:0] pos_inc;
	logic [POSITION_BITS-1:0] span;
	logic [31:0]              span_ext;
	logic [31:0]              pos_ext;
	logic [31:0]              ots_ext;
	logic [15:0]              len16;
	logic [15:0]              pos16;
	logic [15:0]              ots16;
	logic [15:0]              line_new;

	// Saturating advance; also the start of a string after its quote.
	assign pos_inc  = (pos_e != POS_MAX) ? pos_e + 1'b1 : POS_MAX;
	assign span     = (pos_e >= ots_e) ? pos_e - ots_e : '0;
	assign span_ext = 32'(span);
	assign pos_ext  = 32'(pos_e);
	assign ots_ext  = 32'(ots_e);
	assign len16    = (span_ext > 32'h0000_FFFF) ? 16'hFFFF : span_ext[15:0];
	assign pos16    = (pos_ext > 32'h0000_FFFF) ? 16'hFFFF : pos_ext[15:0];
	assign ots16    = (ots_ext > 32'h0000_FFFF) ? 16'hFFFF : ots_ext[15:0];
	assign line_new = (b == jts_pkg::CH_LF && line_e != 16'hFFFF) ? line_e + 16'd1 : line_e;

	// ---------------------------------------------------------------- mode decode
	logic       in_string, in_number, in_keyword, in_error, in_idle;
	logic       str_close, num_end, run_idle;
	logic       kw_true;
	logic [2:0] kw_len;
	logic       kw_match, kw_done;

	assign in_string  = (mode_e == jts_pkg::MODE_STRING);
	assign in_number  = (mode_e == jts_pkg::MODE_NUMBER);
	assign in_keyword = (mode_e == jts_pkg::MODE_TRUE) || (mode_e == jts_pkg::MODE_FALSE);
	assign in_error   = (mode_e == jts_pkg::MODE_ERROR);
	assign in_idle    = !(in_string || in_number || in_keyword || in_error);

	assign str_close = in_string && is_quote && !bs_e;
	assign num_end   = in_number && !is_digit && !is_dot;
	// The byte that ends a number is decoded again as if between tokens.
	assign run_idle  = in_idle || num_end;

	assign kw_true  = (mode_e == jts_pkg::MODE_TRUE);
	assign kw_len   = jts_pkg::keyword_len(kw_true);
	assign kw_match = (kidx_e < kw_len) && (b == jts_pkg::keyword_char(kw_true, kidx_e));
	assign kw_done  = kw_match && ((kidx_e + 3'd1) == kw_len);

	// ---------------------------------------------------------------- next state
	jts_pkg::mode_t           mode_d;
	logic [2:0]               kidx_d;
	logic                     bs_d;
	logic [POSITION_BITS-1:0] ots_d;

	always_comb begin
		mode_d = mode_e;
		kidx_d = kidx_e;
		bs_d   = bs_e;
		ots_d  = ots_e;
		case (mode_e)
			jts_pkg::MODE_STRING: begin
				if (str_close) begin
					mode_d = jts_pkg::MODE_IDLE;
					bs_d   = 1'b0;
				end else begin
					bs_d = is_bslash;
				end
			end
			jts_pkg::MODE_NUMBER: begin
				if (num_end) begin
					mode_d = jts_pkg::MODE_IDLE;
				end
			end
			jts_pkg::MODE_TRUE, jts_pkg::MODE_FALSE: begin
				if (kw_done) begin
					mode_d = jts_pkg::MODE_IDLE;
					kidx_d = 3'd0;
				end else if (kw_match) begin
					kidx_d = kidx_e + 3'd1;
				end else begin
					mode_d = jts_pkg::MODE_ERROR;
					kidx_d = 3'd0;
				end
			end
			jts_pkg::MODE_ERROR: begin
				mode_d = jts_pkg::MODE_ERROR;
			end
			default: begin
				mode_d = jts_pkg::MODE_IDLE;
			end
		endcase
		// Between tokens: open a token or drop into error; symbols and white space change no state here.
		if (run_idle && !is_ws && !is_sym) begin
			if (is_quote) begin
				mode_d = jts_pkg::MODE_STRING;
				bs_d   = 1'b0;
				ots_d  = pos_inc;
			end else if (is_t) begin
				mode_d = jts_pkg::MODE_TRUE;
				kidx_d = 3'd1;
				ots_d  = pos_e;
			end else if (is_f) begin
				mode_d = jts_pkg::MODE_FALSE;
				kidx_d = 3'd1;
				ots_d  = pos_e;
			end else if (is_digit) begin
				mode_d = jts_pkg::MODE_NUMBER;
				ots_d  = pos_e;
			end else begin
				mode_d = jts_pkg::MODE_ERROR;
			end
		end
	end

	// ---------------------------------------------------------------- token build
	jts_pkg::token_t tok_a;
	jts_pkg::token_t tok_b;
	logic            tok_a_valid;
	logic            tok_b_valid;
	jts_pkg::token_t push0;
	jts_pkg::token_t push1;
	logic [1:0]      push_n;

	always_comb begin
		// Token closed by this byte in the current mode, or an error for a keyword mismatch.
		tok_a        = '0;
		tok_a.kind   = jts_pkg::KIND_SYMBOL;
		tok_a.line   = line_new;
		tok_a_valid  = 1'b0;
		if (str_close) begin
			tok_a_valid  = 1'b1;
			tok_a.kind   = jts_pkg::KIND_STRING;
			tok_a.start  = ots16;
			tok_a.length = len16;
		end else if (num_end) begin
			tok_a_valid  = 1'b1;
			tok_a.kind   = jts_pkg::KIND_NUMBER;
			tok_a.start  = ots16;
			tok_a.length = len16;
		end else if (in_keyword && kw_done) begin
			tok_a_valid  = 1'b1;
			tok_a.kind   = jts_pkg::KIND_BOOL;
			tok_a.bval   = kw_true;
			tok_a.start  = ots16;
			tok_a.length = {13'd0, kw_len};
		end else if (in_keyword && !kw_match) begin
			tok_a_valid  = 1'b1;
			tok_a.kind   = jts_pkg::KIND_ERROR;
			tok_a.sym    = b;
			tok_a.start  = pos16;
			tok_a.length = 16'd1;
		end

		// Token produced by decoding the byte between tokens.
		tok_b        = '0;
		tok_b.sym    = b;
		tok_b.start  = pos16;
		tok_b.length = 16'd1;
		tok_b.line   = line_new;
		tok_b.last   = 1'b1;
		tok_b.kind   = is_sym ? jts_pkg::KIND_SYMBOL : jts_pkg::KIND_ERROR;
		tok_b_valid  = run_idle && !is_ws &&
			(is_sym || !(is_quote || is_t || is_f || is_digit));

		push0      = tok_a_valid ? tok_a : tok_b;
		push0.last = !(tok_a_valid && tok_b_valid);
		push1      = tok_b;
		push_n     = {1'b0, tok_a_valid} + {1'b0, tok_b_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jts_pkg::MODE_IDLE;
			kidx_q <= 3'd0;
			bs_q   <= 1'b0;
			pos_q  <= '0;
			ots_q  <= '0;
			line_q <= 16'd1;
		end else if (go) begin
			mode_q <= mode_d;
			kidx_q <= kidx_d;
			bs_q   <= bs_d;
			pos_q  <= pos_inc;
			ots_q  <= ots_d;
			line_q <= line_new;
		end
	end

	// ---------------------------------------------------------------- token queue
	jts_pkg::token_t queue_q [QD];
	logic [QA-1:0]   wr_q;
	logic [QA-1:0]   rd_q;
	logic [QC-1:0]   cnt_q;
	logic            pop;
	logic [QC-1:0]   cnt_after_pop;
	logic [QC-1:0]   cnt_push;
	jts_pkg::token_t head;

	assign pop           = token_valid && !token_stall;
	assign cnt_after_pop = cnt_q - QC'(pop);
	// Advance the input byte only if both of its possible tokens fit.
	assign go            = valid_s1 && (cnt_after_pop <= QC'(QD - 2));
	assign cnt_push      = go ? QC'(push_n) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QA'(cnt_push);
			rd_q  <= rd_q + QA'(pop);
			cnt_q <= cnt_after_pop + cnt_push;
		end
	end

	always_ff @(posedge clk) begin
		if (go && push_n != 2'd0) begin
			queue_q[wr_q] <= push0;
		end
		if (go && push_n == 2'd2) begin
			queue_q[wr_q + QA'(1)] <= push1;
		end
	end

	assign head         = queue_q[rd_q];
	assign token_valid  = (cnt_q != '0);
	assign token_kind   = head.kind;
	assign symbol_byte  = head.sym;
	assign bool_value   = head.bval;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign line_number  = head.line;
	assign last_of_run  = head.last;

	// ---------------------------------------------------------------- assertions
	`JTS_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= QC'(QD), "token queue overfilled")
	`JTS_ASSERT_NOW(a_error_silent,
		go && !first_byte_s1 && mode_q == jts_pkg::MODE_ERROR, push_n == 2'd0,
		"token emitted while in error mode")
	`JTS_ASSERT_NOW(a_pair_queued, token_valid && !last_of_run, cnt_q >= QC'(2),
		"non-final token without its partner queued")
	`JTS_ASSERT_NEXT(a_pos_advance,
		go && !first_byte_s1 && pos_q != POS_MAX, pos_q == $past(pos_q) + 1'b1,
		"byte position did not advance")

endmodule

`default_nettype wire
